### design/blpg_pkg.sv
`timescale 1ns / 1ps

package blpg_pkg;

  // Coordinate and field widths
  localparam int COORD_BITS = 12;
  localparam int ERR_BITS   = COORD_BITS + 2;
  localparam int ROW_BITS   = 13;
  localparam int ADDR_BITS  = 24;
  localparam int COLOR_BITS = 32;
  localparam int PROD_BITS  = COORD_BITS + ROW_BITS;

  localparam logic [ROW_BITS-1:0] ROW_WIDTH_RESET = ROW_BITS'(1280);

  // Item function codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  // One pixel on its way to the address stage
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COLOR_BITS-1:0] color;
    logic                  last;
  } pixel_t;

  // Handshake from the pixel stage to the address stage
  typedef struct packed {
    logic valid;
  } stage_hs_t;

endpackage

### design/bresenham_line_pixel_generator_top.sv
`timescale 1ns / 1ps

// Bresenham line rasteriser. A start word (func 0) loads both endpoints and
// the colour and gives the end pixel at once; each step word (func 1) gives
// the next pixel from the start point toward the end, and the one before the
// end point carries last_pixel. A step with no line in progress gives no
// pixel. One word is accepted per clock while item_stall is low, and each
// pixel passes two registers: one after the line-walk logic, one after the
// y * row_width + x multiply-add that forms pixel_address. The user must
// write row_width via cfg only while the block is idle; it is not enforced.
module bresenham_line_pixel_generator_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic                            func,
  input  logic [blpg_pkg::COORD_BITS-1:0] line_start_x,
  input  logic [blpg_pkg::COORD_BITS-1:0] line_start_y,
  input  logic [blpg_pkg::COORD_BITS-1:0] line_end_x,
  input  logic [blpg_pkg::COORD_BITS-1:0] line_end_y,
  input  logic [blpg_pkg::COLOR_BITS-1:0] draw_color,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [blpg_pkg::ROW_BITS-1:0]   cfg_data,
  output logic                            pixel_valid,
  input  logic                            pixel_stall,
  output logic [blpg_pkg::COORD_BITS-1:0] pixel_x,
  output logic [blpg_pkg::COORD_BITS-1:0] pixel_y,
  output logic [blpg_pkg::ADDR_BITS-1:0]  pixel_address,
  output logic [blpg_pkg::COLOR_BITS-1:0] pixel_color,
  output logic                            last_pixel
);

  logic [blpg_pkg::ROW_BITS-1:0] row_width;
  logic                          a_free;
  logic                          accept;
  blpg_pkg::stage_hs_t           a_hs;
  blpg_pkg::pixel_t              a_pixel;
  logic                          b_take;

  assign cfg_ready  = 1'b1;
  assign item_stall = !a_free;
  assign accept     = item_valid && a_free;

  // Row width register
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= blpg_pkg::ROW_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      row_width <= cfg_data;
    end
  end

  blpg_stepper u_stepper (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .func         (func),
    .line_start_x (line_start_x),
    .line_start_y (line_start_y),
    .line_end_x   (line_end_x),
    .line_end_y   (line_end_y),
    .draw_color   (draw_color),
    .b_take       (b_take),
    .a_free       (a_free),
    .a_hs         (a_hs),
    .a_pixel      (a_pixel)
  );

  blpg_address u_address (
    .clk           (clk),
    .rst           (rst),
    .row_width     (row_width),
    .a_pixel       (a_pixel),
    .a_valid       (a_hs.valid),
    .b_take        (b_take),
    .pixel_valid   (pixel_valid),
    .pixel_stall   (pixel_stall),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color),
    .last_pixel    (last_pixel)
  );

endmodule

### design/blpg_stepper.sv
`timescale 1ns / 1ps

module blpg_stepper (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic                            func,
  input  logic [blpg_pkg::COORD_BITS-1:0] line_start_x,
  input  logic [blpg_pkg::COORD_BITS-1:0] line_start_y,
  input  logic [blpg_pkg::COORD_BITS-1:0] line_end_x,
  input  logic [blpg_pkg::COORD_BITS-1:0] line_end_y,
  input  logic [blpg_pkg::COLOR_BITS-1:0] draw_color,
  input  logic                            b_take,
  output logic                            a_free,
  output blpg_pkg::stage_hs_t             a_hs,
  output blpg_pkg::pixel_t                a_pixel
);

  localparam int CB = blpg_pkg::COORD_BITS;
  localparam int EB = blpg_pkg::ERR_BITS;

  // Line state
  logic [CB-1:0]                   current_x, current_y, target_x, target_y;
  logic [CB-1:0]                   span_x, span_y;
  logic                            step_x_negative, step_y_negative;
  logic signed [EB-1:0]            error_term;
  logic [blpg_pkg::COLOR_BITS-1:0] held_color;
  logic                            line_busy;

  logic [CB-1:0]                   current_x_next, current_y_next;
  logic [CB-1:0]                   target_x_next, target_y_next;
  logic [CB-1:0]                   span_x_next, span_y_next;
  logic                            step_x_negative_next, step_y_negative_next;
  logic signed [EB-1:0]            error_term_next;
  logic [blpg_pkg::COLOR_BITS-1:0] held_color_next;
  logic                            line_busy_next;

  // Stage A
  logic             a_valid;
  blpg_pkg::pixel_t pix_next;
  logic             has_result;

  // Step arithmetic, one bit wider than the error term
  logic signed [EB:0] twice, sx_ext, sy_ext, err_sum;
  logic               go_x, go_y, x_lt, y_lt;

  always_comb begin
    twice  = {error_term, 1'b0};
    sx_ext = $signed({{(EB+1-CB){1'b0}}, span_x});
    sy_ext = $signed({{(EB+1-CB){1'b0}}, span_y});
    go_x   = twice > -sy_ext;
    go_y   = twice < sx_ext;
    err_sum = {error_term[EB-1], error_term}
              - (go_x ? sy_ext : '0)
              + (go_y ? sx_ext : '0);
    x_lt = line_start_x < line_end_x;
    y_lt = line_start_y < line_end_y;
  end

  // Next state and the pixel this item gives
  always_comb begin
    current_x_next       = current_x;
    current_y_next       = current_y;
    target_x_next        = target_x;
    target_y_next        = target_y;
    span_x_next          = span_x;
    span_y_next          = span_y;
    step_x_negative_next = step_x_negative;
    step_y_negative_next = step_y_negative;
    error_term_next      = error_term;
    held_color_next      = held_color;
    line_busy_next       = line_busy;
    pix_next             = '0;
    has_result           = 1'b0;
    if (func == blpg_pkg::FUNC_START) begin
      current_x_next       = line_start_x;
      current_y_next       = line_start_y;
      target_x_next        = line_end_x;
      target_y_next        = line_end_y;
      span_x_next          = x_lt ? line_end_x - line_start_x : line_start_x - line_end_x;
      span_y_next          = y_lt ? line_end_y - line_start_y : line_start_y - line_end_y;
      step_x_negative_next = !x_lt;
      step_y_negative_next = !y_lt;
      error_term_next      = $signed({{(EB-CB){1'b0}}, span_x_next})
                             - $signed({{(EB-CB){1'b0}}, span_y_next});
      held_color_next      = draw_color;
      line_busy_next       = (line_start_x != line_end_x) || (line_start_y != line_end_y);
      // end pixel goes out at once
      pix_next.x           = line_end_x;
      pix_next.y           = line_end_y;
      pix_next.color       = draw_color;
      pix_next.last        = !line_busy_next;
      has_result           = 1'b1;
    end else if (line_busy) begin
      if (go_x) begin
        current_x_next = step_x_negative ? current_x - 1'b1 : current_x + 1'b1;
      end
      if (go_y) begin
        current_y_next = step_y_negative ? current_y - 1'b1 : current_y + 1'b1;
      end
      error_term_next = err_sum[EB-1:0];
      pix_next.x      = current_x;
      pix_next.y      = current_y;
      pix_next.color  = held_color;
      pix_next.last   = (current_x_next == target_x) && (current_y_next == target_y);
      if (pix_next.last) begin
        line_busy_next = 1'b0;
      end
      has_result = 1'b1;
    end
  end

  assign a_free     = !a_valid || b_take;
  assign a_hs.valid = a_valid;

  // Line state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      current_x       <= '0;
      current_y       <= '0;
      target_x        <= '0;
      target_y        <= '0;
      span_x          <= '0;
      span_y          <= '0;
      step_x_negative <= 1'b0;
      step_y_negative <= 1'b0;
      error_term      <= '0;
      held_color      <= '0;
      line_busy       <= 1'b0;
    end else if (accept) begin
      current_x       <= current_x_next;
      current_y       <= current_y_next;
      target_x        <= target_x_next;
      target_y        <= target_y_next;
      span_x          <= span_x_next;
      span_y          <= span_y_next;
      step_x_negative <= step_x_negative_next;
      step_y_negative <= step_y_negative_next;
      error_term      <= error_term_next;
      held_color      <= held_color_next;
      line_busy       <= line_busy_next;
    end
  end

  // Stage A register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= accept && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (a_free && accept) begin
      a_pixel <= pix_next;
    end
  end

endmodule

### design/blpg_address.sv
`timescale 1ns / 1ps

module blpg_address (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [blpg_pkg::ROW_BITS-1:0]   row_width,
  input  blpg_pkg::pixel_t                a_pixel,
  input  logic                            a_valid,
  output logic                            b_take,
  output logic                            pixel_valid,
  input  logic                            pixel_stall,
  output logic [blpg_pkg::COORD_BITS-1:0] pixel_x,
  output logic [blpg_pkg::COORD_BITS-1:0] pixel_y,
  output logic [blpg_pkg::ADDR_BITS-1:0]  pixel_address,
  output logic [blpg_pkg::COLOR_BITS-1:0] pixel_color,
  output logic                            last_pixel
);

  logic                           b_free;
  logic [blpg_pkg::PROD_BITS:0]   addr_full;

  // y * row_width + x, wrapped to the address width
  always_comb begin
    addr_full = (blpg_pkg::PROD_BITS + 1)'(a_pixel.y)
                * (blpg_pkg::PROD_BITS + 1)'(row_width)
                + (blpg_pkg::PROD_BITS + 1)'(a_pixel.x);
  end

  assign b_free = !pixel_valid || !pixel_stall;
  assign b_take = a_valid && b_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (b_free) begin
      pixel_valid <= a_valid;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (b_take) begin
      pixel_x       <= a_pixel.x;
      pixel_y       <= a_pixel.y;
      pixel_address <= addr_full[blpg_pkg::ADDR_BITS-1:0];
      pixel_color   <= a_pixel.color;
      last_pixel    <= a_pixel.last;
    end
  end

endmodule

### bench/bresenham_line_pixel_generator_top_tb.sv
`timescale 1ns / 1ps

module bresenham_line_pixel_generator_top_tb;
  import blpg_pkg::*;

  localparam int QUIET_LIMIT     = 3000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int DRAIN_CYCLES    = 4;

  // Expected pixel word
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [ADDR_BITS-1:0]  addr;
    logic [COLOR_BITS-1:0] colour;
    logic                  last;
  } pixel_exp_t;

  logic                  clk;
  logic                  rst;
  logic                  item_valid;
  logic                  item_stall;
  logic                  func;
  logic [COORD_BITS-1:0] line_start_x;
  logic [COORD_BITS-1:0] line_start_y;
  logic [COORD_BITS-1:0] line_end_x;
  logic [COORD_BITS-1:0] line_end_y;
  logic [COLOR_BITS-1:0] draw_color;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [ROW_BITS-1:0]   cfg_data;
  logic                  pixel_valid;
  logic                  pixel_stall;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [ADDR_BITS-1:0]  pixel_address;
  logic [COLOR_BITS-1:0] pixel_color;
  logic                  last_pixel;

  // Line walker shadow state
  logic [COORD_BITS-1:0] at_x, at_y, goal_x, goal_y, dx_abs, dy_abs;
  logic                  x_down, y_down, line_active;
  int                    bres_err;
  logic [COLOR_BITS-1:0] line_colour;
  logic [ROW_BITS-1:0]   row_w;

  pixel_exp_t pending_pixels[$];
  int         mismatches;
  int         quiet_cycles;
  int         idle_pct;
  int         stall_pct;
  bit         hold_off_req;

  bresenham_line_pixel_generator_top u_top (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .func          (func),
    .line_start_x  (line_start_x),
    .line_start_y  (line_start_y),
    .line_end_x    (line_end_x),
    .line_end_y    (line_end_y),
    .draw_color    (draw_color),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .pixel_valid   (pixel_valid),
    .pixel_stall   (pixel_stall),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color),
    .last_pixel    (last_pixel)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Advance the line walker by one accepted word; returns 1 when a pixel is due
  function automatic bit walk_line(input logic f,
                                   input logic [COORD_BITS-1:0] sx, sy, ex, ey,
                                   input logic [COLOR_BITS-1:0] colour,
                                   output pixel_exp_t pix);
    logic [COORD_BITS-1:0] px, py;
    int                    twice;
    pix = '0;
    if (f == FUNC_START) begin
      at_x        = sx;
      at_y        = sy;
      goal_x      = ex;
      goal_y      = ey;
      dx_abs      = (sx < ex) ? ex - sx : sx - ex;
      dy_abs      = (sy < ey) ? ey - sy : sy - ey;
      x_down      = !(sx < ex);
      y_down      = !(sy < ey);
      bres_err    = int'(dx_abs) - int'(dy_abs);
      line_colour = colour;
      line_active = (sx != ex) || (sy != ey);
      px          = ex;
      py          = ey;
      pix.last    = !line_active;
    end else begin
      if (!line_active) return 1'b0;
      px    = at_x;
      py    = at_y;
      twice = bres_err * 2;
      if (twice > -int'(dy_abs)) begin
        bres_err -= int'(dy_abs);
        at_x = x_down ? at_x - 12'd1 : at_x + 12'd1;
      end
      if (twice < int'(dx_abs)) begin
        bres_err += int'(dx_abs);
        at_y = y_down ? at_y - 12'd1 : at_y + 12'd1;
      end
      pix.last = (at_x == goal_x) && (at_y == goal_y);
      if (pix.last) line_active = 1'b0;
    end
    pix.x      = px;
    pix.y      = py;
    pix.colour = line_colour;
    // low 24 bits of y * row_width + x
    pix.addr   = ADDR_BITS'(32'(py) * 32'(row_w) + 32'(px));
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Monitor: check pixel words, predict from accepted words, track row width
  always @(posedge clk) begin : monitor
    pixel_exp_t want;
    bit         moved;
    moved = 1'b0;
    if (!rst) begin
      if (pixel_valid && !pixel_stall) begin
        moved = 1'b1;
        if (pending_pixels.size() == 0) begin
          $error("unexpected pixel word: x %0d y %0d", pixel_x, pixel_y);
          mismatches++;
        end else begin
          want = pending_pixels.pop_front();
          check_field("pixel_x", 32'(want.x), 32'(pixel_x));
          check_field("pixel_y", 32'(want.y), 32'(pixel_y));
          check_field("pixel_address", 32'(want.addr), 32'(pixel_address));
          check_field("pixel_color", want.colour, pixel_color);
          check_field("last_pixel", 32'(want.last), 32'(last_pixel));
        end
      end
      if (item_valid && !item_stall) begin
        moved = 1'b1;
        if (walk_line(func, line_start_x, line_start_y, line_end_x, line_end_y,
                      draw_color, want))
          pending_pixels.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        row_w = cfg_data;
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  // Watchdog on lack of progress
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("bresenham_line_pixel_generator_top_tb failed");
    $finish;
  end

  // Pixel receiver: random stall, plus one long hold-off on request
  initial begin
    pixel_stall <= 1'b0;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        repeat (HOLD_OFF_CYCLES) begin
          pixel_stall <= 1'b1;
          @(posedge clk);
        end
      end
      pixel_stall <= ($urandom_range(99) < stall_pct);
      @(posedge clk);
    end
  end

  // Offer one word, with random idle gaps ahead of it; returns at acceptance
  task automatic send_word(input logic f, input logic [COORD_BITS-1:0] sx, sy, ex, ey,
                           input logic [COLOR_BITS-1:0] colour);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid   <= 1'b1;
    func         <= f;
    line_start_x <= sx;
    line_start_y <= sy;
    line_end_x   <= ex;
    line_end_y   <= ey;
    draw_color   <= colour;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // Step word; the coordinate and colour fields are don't-care, so randomise them
  task automatic send_step();
    send_word(FUNC_STEP, COORD_BITS'($urandom_range(4095)), COORD_BITS'($urandom_range(4095)),
              COORD_BITS'($urandom_range(4095)), COORD_BITS'($urandom_range(4095)),
              $urandom());
  endtask

  task automatic draw_line(input logic [COORD_BITS-1:0] sx, sy, ex, ey,
                           input logic [COLOR_BITS-1:0] colour, input int steps);
    send_word(FUNC_START, sx, sy, ex, ey, colour);
    repeat (steps) send_step();
  endtask

  // Bring the block to rest: no line open, no pixel outstanding, pipeline empty
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    if (line_active) begin
      send_word(FUNC_START, 12'd7, 12'd7, 12'd7, 12'd7, $urandom());
      item_valid <= 1'b0;
      @(posedge clk);
    end
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_row_width(input logic [ROW_BITS-1:0] width);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= width;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hand-picked lines at the reset row width
  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    send_step();                                                  // idle step
    draw_line(12'd0, 12'd0, 12'd0, 12'd0, 32'h0000_0000, 1);      // single pixel
    draw_line(12'd4095, 12'd4095, 12'd4095, 12'd4095, 32'hFFFF_FFFF, 0);
    draw_line(12'd0, 12'd5, 12'd4, 12'd5, 32'hA5A5_5A5A, 4);      // horizontal
    draw_line(12'd10, 12'd10, 12'd10, 12'd7, 32'h0000_00FF, 3);   // vertical, y down
    draw_line(12'd4095, 12'd0, 12'd4093, 12'd2, 32'h1234_5678, 2); // diagonal, x down
    draw_line(12'd0, 12'd0, 12'd4095, 12'd4095, 32'hFFFF_0000, 2); // cut short
    draw_line(12'd100, 12'd200, 12'd102, 12'd205, 32'h8000_0001, 6); // steep, overrun
  endtask

  // Address extremes: narrowest, widest without wrap, zero and wrapping row widths
  task automatic test_row_widths();
    logic [ROW_BITS-1:0] widths[4];
    widths = '{13'd1, 13'd4096, 13'd0, 13'd8191};
    foreach (widths[i]) begin
      write_row_width(widths[i]);
      draw_line(12'd4095, 12'd4095, 12'd4095, 12'd4095, $urandom(), 0);
      draw_line(12'd4095, 12'd4094, 12'd4093, 12'd4095, $urandom(), 3);
      draw_line(12'd0, 12'd0, 12'd1, 12'd0, $urandom(), 1);
    end
  endtask

  // Long receiver hold-off while steps keep coming, so the input backs up
  task automatic test_backpressure();
    write_row_width(13'd640);
    idle_pct  = 0;
    stall_pct = 0;
    send_word(FUNC_START, 12'd0, 12'd0, 12'd300, 12'd40, $urandom());
    hold_off_req = 1'b1;
    repeat (60) send_step();
    draw_line(12'd50, 12'd60, 12'd45, 12'd58, $urandom(), 5);
  endtask

  // Mostly well-formed lines with random content, some noise and cut-short lines
  task automatic test_random(input int n_words, input int gap_pct, input int hold_pct,
                             input logic [ROW_BITS-1:0] width);
    int                    done_words, pick, need, steps, dx, dy, t;
    logic [COORD_BITS-1:0] sx, sy, ex, ey;
    logic                  f;
    write_row_width(width);
    idle_pct   = gap_pct;
    stall_pct  = hold_pct;
    done_words = 0;
    while (done_words < n_words) begin
      pick = $urandom_range(99);
      sx   = COORD_BITS'($urandom_range(4095));
      sy   = COORD_BITS'($urandom_range(4095));
      if (pick < 8) begin
        // stray word of either kind
        f = 1'($urandom_range(1));
        send_word(f, sx, sy, COORD_BITS'($urandom_range(4095)),
                  COORD_BITS'($urandom_range(4095)), $urandom());
        if (f == FUNC_START) done_words++;
      end else begin
        if (pick < 92) begin
          dx = int'($urandom_range(30)) - 15;
          dy = int'($urandom_range(30)) - 15;
          t  = int'(sx) + dx;
          ex = COORD_BITS'((t < 0 || t > 4095) ? int'(sx) - dx : t);
          t  = int'(sy) + dy;
          ey = COORD_BITS'((t < 0 || t > 4095) ? int'(sy) - dy : t);
        end else begin
          ex = COORD_BITS'($urandom_range(4095));
          ey = COORD_BITS'($urandom_range(4095));
        end
        dx   = int'((sx < ex) ? ex - sx : sx - ex);
        dy   = int'((sy < ey) ? ey - sy : sy - ey);
        need = (dx > dy) ? dx : dy;
        pick = $urandom_range(99);
        if (need > 40)
          steps = $urandom_range(24);
        else if (pick < 70)
          steps = need;
        else if (pick < 85)
          steps = need + $urandom_range(1, 3);
        else
          steps = $urandom_range(need);
        draw_line(sx, sy, ex, ey, $urandom(), steps);
        done_words += 1 + ((steps < need) ? steps : need);
      end
    end
  endtask

  initial begin
    mismatches   = 0;
    quiet_cycles = 0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_off_req = 1'b0;
    line_active  = 1'b0;
    at_x = '0; at_y = '0; goal_x = '0; goal_y = '0; dx_abs = '0; dy_abs = '0;
    x_down = 1'b0; y_down = 1'b0; bres_err = 0; line_colour = '0;
    row_w = ROW_WIDTH_RESET;
    rst          <= 1'b1;
    item_valid   <= 1'b0;
    func         <= FUNC_START;
    line_start_x <= '0;
    line_start_y <= '0;
    line_end_x   <= '0;
    line_end_y   <= '0;
    draw_color   <= '0;
    cfg_valid    <= 1'b0;
    cfg_data     <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_row_widths();
    test_backpressure();
    test_random(320, 0, 0, 13'd1280);
    test_random(320, 75, 0, ROW_BITS'($urandom_range(1, 4096)));
    test_random(320, 0, 75, 13'd4096);
    test_random(320, 17, 17, 13'd1);

    settle();
    if (mismatches == 0)
      $display("bresenham_line_pixel_generator_top_tb passed");
    else
      $display("bresenham_line_pixel_generator_top_tb failed");
    $finish;
  end

endmodule
